@@ hdl/rnd7_pkg.sv @@
package rnd7_pkg;

  localparam int unsigned MANT_W       = 96;
  localparam int unsigned LOW_W        = 64;
  localparam int unsigned HIGH_W       = 32;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned KEEP_DIGITS  = 7;
  localparam int unsigned MAX_POW      = 28;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned RADIX        = 10;
  localparam int unsigned HALF_DIGIT   = 5;
  localparam int unsigned CHUNK_W      = 16;
  localparam int unsigned NUM_CHUNKS   = MANT_W / CHUNK_W;
  localparam int unsigned CHUNK_CNT_W  = $clog2(NUM_CHUNKS);
  localparam int unsigned CUR_W        = DIGIT_W + CHUNK_W;
  localparam int unsigned RECIP_SHIFT  = 23;
  localparam logic [CUR_W-1:0] RECIP   = CUR_W'((2 ** RECIP_SHIFT + 3) / RADIX);

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t OP_CMP   = 2'd0;
  localparam alu_op_t OP_DIV   = 2'd1;
  localparam alu_op_t OP_INC   = 2'd2;
  localparam alu_op_t OP_MUL10 = 2'd3;

  typedef struct packed {
    alu_op_t             op;
    logic [MANT_W-1:0]   a;
    logic [MANT_W-1:0]   b;
    logic [DIGIT_W-1:0]  rem;
  } alu_req_t;

  typedef struct packed {
    logic [MANT_W-1:0]   res;
    logic [DIGIT_W-1:0]  rem;
    logic                ge;
  } alu_rsp_t;

  function automatic logic [MANT_W-1:0] pow10(input logic [CNT_W-1:0] k);
    logic [MANT_W-1:0] p;
    case (k)
      5'd0:  p = 96'd1;
      5'd1:  p = 96'd10;
      5'd2:  p = 96'd100;
      5'd3:  p = 96'd1000;
      5'd4:  p = 96'd10000;
      5'd5:  p = 96'd100000;
      5'd6:  p = 96'd1000000;
      5'd7:  p = 96'd10000000;
      5'd8:  p = 96'd100000000;
      5'd9:  p = 96'd1000000000;
      5'd10: p = 96'd10000000000;
      5'd11: p = 96'd100000000000;
      5'd12: p = 96'd1000000000000;
      5'd13: p = 96'd10000000000000;
      5'd14: p = 96'd100000000000000;
      5'd15: p = 96'd1000000000000000;
      5'd16: p = 96'd10000000000000000;
      5'd17: p = 96'd100000000000000000;
      5'd18: p = 96'd1000000000000000000;
      5'd19: p = 96'd10000000000000000000;
      5'd20: p = 96'd100000000000000000000;
      5'd21: p = 96'd1000000000000000000000;
      5'd22: p = 96'd10000000000000000000000;
      5'd23: p = 96'd100000000000000000000000;
      5'd24: p = 96'd1000000000000000000000000;
      5'd25: p = 96'd10000000000000000000000000;
      5'd26: p = 96'd100000000000000000000000000;
      5'd27: p = 96'd1000000000000000000000000000;
      5'd28: p = 96'd10000000000000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/rnd7_if.sv @@
interface rnd7_in_if;
  logic                         valid;
  logic                         ready;
  logic [rnd7_pkg::LOW_W-1:0]   mantissa_low;
  logic [rnd7_pkg::HIGH_W-1:0]  mantissa_high;

  modport source (output valid, output mantissa_low, output mantissa_high, input ready);
  modport sink (input valid, input mantissa_low, input mantissa_high, output ready);
endinterface

interface rnd7_out_if;
  logic                         valid;
  logic                         ready;
  logic [rnd7_pkg::LOW_W-1:0]   result_low;
  logic [rnd7_pkg::HIGH_W-1:0]  result_high;
  logic [rnd7_pkg::CNT_W-1:0]   dropped_count;

  modport source (output valid, output result_low, output result_high,
                  output dropped_count, input ready);
  modport sink (input valid, input result_low, input result_high,
                input dropped_count, output ready);
endinterface

@@ hdl/rnd7_alu.sv @@
module rnd7_alu (
  input  rnd7_pkg::alu_req_t req_i,
  output rnd7_pkg::alu_rsp_t rsp_o
);

  logic [rnd7_pkg::CUR_W-1:0]     cur;
  logic [2*rnd7_pkg::CUR_W-1:0]   prod;
  logic [rnd7_pkg::CHUNK_W:0]     q_est;
  logic [rnd7_pkg::CUR_W-1:0]     q_wide;
  logic [rnd7_pkg::CUR_W-1:0]     q_x10;
  logic [rnd7_pkg::CUR_W-1:0]     rem_est;
  logic [rnd7_pkg::CHUNK_W-1:0]   q_fix;
  logic [rnd7_pkg::DIGIT_W-1:0]   rem_fix;
  logic [rnd7_pkg::MANT_W-1:0]    mul10;

  // One long-division step: the running remainder and the top 16-bit chunk are
  // divided by ten through a reciprocal multiply, then corrected once.
  assign cur     = {req_i.rem, req_i.a[rnd7_pkg::MANT_W-1 -: rnd7_pkg::CHUNK_W]};
  assign prod    = cur * rnd7_pkg::RECIP;
  assign q_est   = prod[rnd7_pkg::RECIP_SHIFT +: rnd7_pkg::CHUNK_W+1];
  assign q_wide  = rnd7_pkg::CUR_W'(q_est);
  assign q_x10   = (q_wide << 3) + (q_wide << 1);
  assign rem_est = cur - q_x10;

  always_comb begin
    if (rem_est >= rnd7_pkg::CUR_W'(rnd7_pkg::RADIX)) begin
      q_fix   = q_est[rnd7_pkg::CHUNK_W-1:0] + 1'b1;
      rem_fix = rnd7_pkg::DIGIT_W'(rem_est - rnd7_pkg::CUR_W'(rnd7_pkg::RADIX));
    end else begin
      q_fix   = q_est[rnd7_pkg::CHUNK_W-1:0];
      rem_fix = rem_est[rnd7_pkg::DIGIT_W-1:0];
    end
  end

  assign mul10 = (req_i.a << 3) + (req_i.a << 1);

  always_comb begin
    rsp_o.res = req_i.a;
    rsp_o.rem = '0;
    rsp_o.ge  = (req_i.a >= req_i.b);
    case (req_i.op)
      rnd7_pkg::OP_CMP: begin
        rsp_o.res = req_i.a;
      end
      rnd7_pkg::OP_DIV: begin
        rsp_o.res = {req_i.a[rnd7_pkg::MANT_W-rnd7_pkg::CHUNK_W-1:0], q_fix};
        rsp_o.rem = rem_fix;
      end
      rnd7_pkg::OP_INC: begin
        rsp_o.res = req_i.a + 1'b1;
      end
      rnd7_pkg::OP_MUL10: begin
        rsp_o.res = mul10;
      end
      default: begin
        rsp_o.res = req_i.a;
      end
    endcase
  end

endmodule

@@ hdl/round_96bit_to_7_significant_digits.sv @@
// Rounds a 96-bit unsigned mantissa to its seven most significant decimal
// digits, half to even, and returns it at its original magnitude together with
// the number of digits rounded away. The block takes one transaction at a time
// and is not ready while it works. With D dropped digits the work is up to D+1
// power-of-ten compares to count digits, six 16-bit divide-by-ten steps per
// dropped digit, one rounding increment and D multiplications by ten, all on
// one shared 96-bit arithmetic unit. A finished result waits in an output
// register, so the next input transaction can be taken before it is consumed.
module round_96bit_to_7_significant_digits (
  input  logic     clk_i,
  input  logic     rst_ni,
  rnd7_in_if.sink  in_i,
  rnd7_out_if.source out_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COUNT = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]                         state_q, state_d;
  logic [rnd7_pkg::MANT_W-1:0]        val_q, val_d;
  logic [rnd7_pkg::CNT_W-1:0]         k_q, k_d;
  logic [rnd7_pkg::CNT_W-1:0]         drop_q, drop_d;
  logic [rnd7_pkg::CNT_W-1:0]         left_q, left_d;
  logic [rnd7_pkg::CHUNK_CNT_W-1:0]   chunk_q, chunk_d;
  logic [rnd7_pkg::DIGIT_W-1:0]       rem_q, rem_d;
  logic [rnd7_pkg::DIGIT_W-1:0]       last_q, last_d;
  logic                               sticky_q, sticky_d;
  logic                               out_valid_q, out_valid_d;
  logic [rnd7_pkg::MANT_W-1:0]        res_q, res_d;
  logic [rnd7_pkg::CNT_W-1:0]         res_drop_q, res_drop_d;
  logic                               round_up;
  rnd7_pkg::alu_req_t                 alu_req;
  rnd7_pkg::alu_rsp_t                 alu_rsp;

  rnd7_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign round_up = (last_q > rnd7_pkg::DIGIT_W'(rnd7_pkg::HALF_DIGIT)) ||
                    ((last_q == rnd7_pkg::DIGIT_W'(rnd7_pkg::HALF_DIGIT)) &&
                     (sticky_q || val_q[0]));

  always_comb begin
    alu_req.a   = val_q;
    alu_req.b   = rnd7_pkg::pow10(k_q);
    alu_req.rem = rem_q;
    case (state_q)
      ST_COUNT: alu_req.op = rnd7_pkg::OP_CMP;
      ST_DIV:   alu_req.op = rnd7_pkg::OP_DIV;
      ST_ROUND: alu_req.op = rnd7_pkg::OP_INC;
      ST_MUL:   alu_req.op = rnd7_pkg::OP_MUL10;
      default:  alu_req.op = rnd7_pkg::OP_CMP;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    k_d         = k_q;
    drop_d      = drop_q;
    left_d      = left_q;
    chunk_d     = chunk_q;
    rem_d       = rem_q;
    last_d      = last_q;
    sticky_d    = sticky_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    res_drop_d  = res_drop_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          val_d   = {in_i.mantissa_high, in_i.mantissa_low};
          k_d     = rnd7_pkg::CNT_W'(rnd7_pkg::KEEP_DIGITS);
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if ((k_q <= rnd7_pkg::CNT_W'(rnd7_pkg::MAX_POW)) && alu_rsp.ge) begin
          k_d = k_q + 1'b1;
        end else if (k_q == rnd7_pkg::CNT_W'(rnd7_pkg::KEEP_DIGITS)) begin
          drop_d  = '0;
          state_d = ST_FIN;
        end else begin
          drop_d   = k_q - rnd7_pkg::CNT_W'(rnd7_pkg::KEEP_DIGITS);
          left_d   = k_q - rnd7_pkg::CNT_W'(rnd7_pkg::KEEP_DIGITS);
          chunk_d  = '0;
          rem_d    = '0;
          last_d   = '0;
          sticky_d = 1'b0;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        val_d = alu_rsp.res;
        rem_d = alu_rsp.rem;
        if (chunk_q == rnd7_pkg::CHUNK_CNT_W'(rnd7_pkg::NUM_CHUNKS - 1)) begin
          chunk_d  = '0;
          rem_d    = '0;
          last_d   = alu_rsp.rem;
          sticky_d = sticky_q || (last_q != '0);
          left_d   = left_q - 1'b1;
          if (left_q == rnd7_pkg::CNT_W'(1)) begin
            state_d = ST_ROUND;
          end
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      ST_ROUND: begin
        if (round_up) begin
          val_d = alu_rsp.res;
        end
        left_d  = drop_q;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        val_d  = alu_rsp.res;
        left_d = left_q - 1'b1;
        if (left_q == rnd7_pkg::CNT_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          res_d       = val_q;
          res_drop_d  = drop_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      drop_q      <= '0;
      left_q      <= '0;
      chunk_q     <= '0;
      rem_q       <= '0;
      last_q      <= '0;
      sticky_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      drop_q      <= drop_d;
      left_q      <= left_d;
      chunk_q     <= chunk_d;
      rem_q       <= rem_d;
      last_q      <= last_d;
      sticky_q    <= sticky_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    res_q      <= res_d;
    res_drop_q <= res_drop_d;
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.result_low    = res_q[rnd7_pkg::LOW_W-1:0];
  assign out_o.result_high   = res_q[rnd7_pkg::MANT_W-1:rnd7_pkg::LOW_W];
  assign out_o.dropped_count = res_drop_q;

endmodule

@@ verif/round_96bit_to_7_significant_digits_tb.sv @@
`timescale 1ns / 1ps

module round_96bit_to_7_significant_digits_tb;

  localparam int unsigned CLK_HALF_NS    = 10;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned RANDOM_ITEMS   = 750;
  localparam int unsigned IDLE_PERCENT   = 31;
  localparam int unsigned CALM_FIRST     = 300;
  localparam int unsigned CALM_LAST      = 420;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  typedef logic [rnd7_pkg::MANT_W-1:0] mant_t;

  typedef struct packed {
    logic [rnd7_pkg::LOW_W-1:0]  low;
    logic [rnd7_pkg::HIGH_W-1:0] high;
    logic [rnd7_pkg::CNT_W-1:0]  dropped;
  } rounded_t;

  logic clk_i;
  logic rst_ni;

  rnd7_in_if  in_bus ();
  rnd7_out_if out_bus ();

  round_96bit_to_7_significant_digits dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  mant_t       mantissa_q[$];
  rounded_t    rounded_q[$];
  mant_t       next_mantissa;
  logic        in_taken;
  int unsigned sent_count;
  int unsigned received_count;
  int unsigned total_count;
  int unsigned cycle_count;
  bit          failed;

  always begin
    clk_i = 1'b1;
    #(CLK_HALF_NS);
    clk_i = 1'b0;
    #(CLK_HALF_NS);
  end

  function automatic mant_t ten_pow(input int unsigned n);
    mant_t p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic mant_t rand_mant();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Keeps KEEP_DIGITS significant digits, rounding half to even, and scales back.
  function automatic rounded_t round_half_even(input mant_t m);
    mant_t       v;
    int unsigned digits;
    int unsigned drop;
    logic [3:0]  last;
    logic        sticky;
    rounded_t    r;
    v = m;
    digits = 0;
    while (v != 0) begin
      v = v / 10;
      digits++;
    end
    v = m;
    drop = 0;
    last = '0;
    sticky = 1'b0;
    if (digits > rnd7_pkg::KEEP_DIGITS) begin
      drop = digits - rnd7_pkg::KEEP_DIGITS;
      for (int unsigned i = 0; i < drop; i++) begin
        sticky = sticky | (last != 0);
        last = 4'(v % 10);
        v = v / 10;
      end
      if (last > rnd7_pkg::HALF_DIGIT ||
          (last == rnd7_pkg::HALF_DIGIT && (sticky || v[0]))) begin
        v = v + 1;
      end
      for (int unsigned i = 0; i < drop; i++) begin
        v = v * 10;
      end
    end
    r.low = v[rnd7_pkg::LOW_W-1:0];
    r.high = v[rnd7_pkg::MANT_W-1:rnd7_pkg::LOW_W];
    r.dropped = rnd7_pkg::CNT_W'(drop);
    return r;
  endfunction

  function automatic mant_t random_mantissa();
    mant_t       q;
    mant_t       v;
    int unsigned k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = rand_mant() >> $urandom_range(0, rnd7_pkg::MANT_W - 1);
      4, 5: begin
        q = $urandom_range(1000000, 9999999);
        k = $urandom_range(1, 21);
        v = q * ten_pow(k) + rnd7_pkg::HALF_DIGIT * ten_pow(k - 1);
        if (k >= 2 && $urandom_range(0, 1) == 1) begin
          v = v + (rand_mant() % ten_pow(k - 1));
        end
      end
      6: begin
        k = $urandom_range(rnd7_pkg::KEEP_DIGITS, 28);
        if ($urandom_range(0, 1) == 1) begin
          v = ten_pow(k) - 1 - $urandom_range(0, 20);
        end else begin
          v = ten_pow(k) + $urandom_range(0, 20);
        end
      end
      7: begin
        k = $urandom_range(1, 21);
        v = 9999999 * ten_pow(k) + (rand_mant() % ten_pow(k));
      end
      default: v = rand_mant();
    endcase
    return v;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_bus.valid || in_taken) begin
        if (mantissa_q.size() > 0 &&
            ((sent_count >= CALM_FIRST && sent_count < CALM_LAST) ||
             $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          next_mantissa = mantissa_q.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.mantissa_low <= next_mantissa[rnd7_pkg::LOW_W-1:0];
          in_bus.mantissa_high <= next_mantissa[rnd7_pkg::MANT_W-1:rnd7_pkg::LOW_W];
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= (received_count >= CALM_FIRST && received_count < CALM_LAST) ||
                       ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk_i) begin
    rounded_t want;
    if (rst_ni) begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        rounded_q.push_back(round_half_even({in_bus.mantissa_high, in_bus.mantissa_low}));
        sent_count++;
      end
      if (out_bus.valid && out_bus.ready) begin
        received_count++;
        if (rounded_q.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual %h %h %0d", $time,
                   out_bus.result_high, out_bus.result_low, out_bus.dropped_count);
          failed = 1'b1;
        end else begin
          want = rounded_q.pop_front();
          if (out_bus.result_low !== want.low) begin
            $display("%0t: result_low expected %h actual %h", $time, want.low,
                     out_bus.result_low);
            failed = 1'b1;
          end
          if (out_bus.result_high !== want.high) begin
            $display("%0t: result_high expected %h actual %h", $time, want.high,
                     out_bus.result_high);
            failed = 1'b1;
          end
          if (out_bus.dropped_count !== want.dropped) begin
            $display("%0t: dropped_count expected %0d actual %0d", $time, want.dropped,
                     out_bus.dropped_count);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("round_96bit_to_7_significant_digits: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mantissa_low = '0;
    in_bus.mantissa_high = '0;
    out_bus.ready = 1'b0;
    in_taken = 1'b0;
    next_mantissa = '0;
    sent_count = 0;
    received_count = 0;
    cycle_count = 0;
    failed = 1'b0;

    mantissa_q.push_back(96'd0);
    mantissa_q.push_back(96'd1);
    mantissa_q.push_back(96'd9999999);
    mantissa_q.push_back(96'd10000000);
    mantissa_q.push_back(96'd12345645);
    mantissa_q.push_back(96'd12345655);
    mantissa_q.push_back(96'd1234564501);
    mantissa_q.push_back(96'd99999995);
    mantissa_q.push_back(96'd99999994);
    mantissa_q.push_back({rnd7_pkg::MANT_W{1'b1}});
    mantissa_q.push_back(ten_pow(28));
    mantissa_q.push_back(ten_pow(28) - 1);
    mantissa_q.push_back({{rnd7_pkg::HIGH_W{1'b1}}, {rnd7_pkg::LOW_W{1'b0}}});
    mantissa_q.push_back({{rnd7_pkg::HIGH_W{1'b0}}, {rnd7_pkg::LOW_W{1'b1}}});
    mantissa_q.push_back({24{4'h5}});
    mantissa_q.push_back({24{4'hA}});
    mantissa_q.push_back(1234566 * ten_pow(22) + rnd7_pkg::HALF_DIGIT * ten_pow(21));
    mantissa_q.push_back(1234567 * ten_pow(22) + rnd7_pkg::HALF_DIGIT * ten_pow(21));
    mantissa_q.push_back(9999999 * ten_pow(21) + rnd7_pkg::HALF_DIGIT * ten_pow(20));
    mantissa_q.push_back(ten_pow(rnd7_pkg::KEEP_DIGITS) - 1);
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      mantissa_q.push_back(random_mantissa());
    end
    total_count = mantissa_q.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sent_count < total_count) @(posedge clk_i);
    while (rounded_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("round_96bit_to_7_significant_digits: match");
    end else begin
      $display("round_96bit_to_7_significant_digits: mismatch");
    end
    $finish;
  end

endmodule
